@@ sv/meab_pkg.sv @@
package meab_pkg;

	// Store geometry and defaults for the top-level parameters.
	localparam int FAST_DEPTH      = 60;
	localparam int FAST_AW         = $clog2(FAST_DEPTH);
	localparam int FAST_HALF_OFS   = FAST_DEPTH / 2;
	localparam int SLOW_DEPTH_DEF  = 6;
	localparam int SAMPLE_BITS_DEF = 12;

	// Three interleaved channels per store, ten samples per fast estimate.
	localparam int CHANNELS = 3;
	localparam int TAPS     = 10;
	localparam int TAP_CW   = $clog2(TAPS);

	localparam int VALUE_W = 12;

	// Request command codes.
	localparam logic [2:0] CMD_WR_FAST   = 3'd0;
	localparam logic [2:0] CMD_WR_SLOW   = 3'd1;
	localparam logic [2:0] CMD_FAST_DONE = 3'd2;
	localparam logic [2:0] CMD_SLOW_DONE = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;

	// Read port ranges.
	localparam logic [2:0] PORT_FAST_LAST  = 3'd2;
	localparam logic [2:0] PORT_SLOW_FIRST = 3'd3;
	localparam logic [2:0] PORT_SLOW_LAST  = 3'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [5:0]  write_index;
		logic [11:0] sample;
		logic [2:0]  port;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               error;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DRAIN,
		ST_PART,
		ST_SUM,
		ST_MUL,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SRC_FAST,
		SRC_SLOW,
		SRC_ERR
	} src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_fast;
		logic wr_slow;
		logic flip_fast;
		logic flip_slow;
		logic start_fast;
		logic start_slow;
		logic fetch;
		logic load_out;
		src_t out_sel;
	} dp_cmd_t;

endpackage

@@ sv/meab_dp.sv @@
module meab_dp #(
	parameter int SLOW_DEPTH  = meab_pkg::SLOW_DEPTH_DEF,
	parameter int SAMPLE_BITS = meab_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  meab_pkg::req_t    req,
	input  meab_pkg::dp_cmd_t cmd,
	output meab_pkg::rsp_t    rsp
);
	import meab_pkg::*;

	localparam int SW      = SAMPLE_BITS;
	localparam int SLOW_AW = $clog2(SLOW_DEPTH);
	localparam int SUM_W   = SW + 2;
	// Floor division by three as a multiply by a rounded-up reciprocal.
	localparam int DIV_SH  = SUM_W + 1;
	localparam int DIV_MUL = (2 ** DIV_SH) / 3 + 1;
	localparam int PROD_W  = SUM_W + DIV_SH - 1;

	function automatic logic [SW-1:0] mid3(input logic [SW-1:0] a, input logic [SW-1:0] b,
			input logic [SW-1:0] c);
		logic [SW-1:0] r;
		if ((a <= b && b <= c) || (c <= b && b <= a))
			r = b;
		else if ((b <= a && a <= c) || (c <= a && a <= b))
			r = a;
		else
			r = c;
		return r;
	endfunction

	function automatic logic [SW-1:0] pick4(input logic [SW-1:0] a, input logic [SW-1:0] b,
			input logic [SW-1:0] c, input logic [SW-1:0] d);
		logic [SW-1:0] r;
		if ((a <= b && b <= c && c <= d) || (d <= c && c <= b && b <= a))
			r = b;
		else if ((b <= a && a <= c && c <= d) || (d <= c && c <= a && a <= b))
			r = a;
		else if ((b <= c && c <= a && a <= d) || (d <= a && a <= c && c <= b))
			r = c;
		else
			r = d;
		return r;
	endfunction

	logic                  fast_half_q;
	logic                  slow_half_q;
	logic [SW-1:0]         fast_mem [FAST_DEPTH];
	logic [FAST_DEPTH-1:0] fast_vld_q;
	logic [SW-1:0]         slow_mem [SLOW_DEPTH];
	logic [SLOW_DEPTH-1:0] slow_vld_q;
	logic [FAST_AW-1:0]    fast_addr_q;
	logic [FAST_AW:0]      fast_addr_inc;
	logic [FAST_AW-1:0]    fast_addr_nxt;
	logic [FAST_AW-1:0]    fast_addr_start;
	logic [SW-1:0]         fast_rd_q;
	logic                  fast_rd_vld_q;
	logic [SW-1:0]         fast_word;
	logic                  rd_pend_s1;
	logic [SW-1:0]         taps_q [TAPS];
	logic [6:0]            slow_pos;
	logic [6:0]            slow_pos_wrap;
	logic [SLOW_AW-1:0]    slow_addr;
	logic [SW-1:0]         slow_rd_q;
	logic                  slow_rd_vld_q;
	logic [SW-1:0]         slow_word;
	logic                  fast_wr_ok;
	logic                  slow_wr_ok;
	logic [SW-1:0]         wr_sample;
	logic [SW-1:0]         part_s2 [3];
	logic [SUM_W-1:0]      sum_s3;
	logic [PROD_W-1:0]     prod_s4;
	logic [PROD_W-1:0]     quot;
	rsp_t                  rsp_q;

	assign wr_sample  = SW'(req.sample);
	assign fast_wr_ok = req.write_index < FAST_AW'(FAST_DEPTH);
	assign slow_wr_ok = {1'b0, req.write_index} < 7'(SLOW_DEPTH);

	// Half-select flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_half_q <= 1'b1;
			slow_half_q <= 1'b1;
		end else begin
			if (cmd.flip_fast)
				fast_half_q <= ~fast_half_q;
			if (cmd.flip_slow)
				slow_half_q <= ~slow_half_q;
		end
	end

	// Per-entry written flags; an unwritten entry reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_vld_q <= '0;
			slow_vld_q <= '0;
		end else begin
			if (cmd.wr_fast && fast_wr_ok)
				fast_vld_q[req.write_index] <= 1'b1;
			if (cmd.wr_slow && slow_wr_ok)
				slow_vld_q[req.write_index[SLOW_AW-1:0]] <= 1'b1;
		end
	end

	// Fast store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_fast && fast_wr_ok)
			fast_mem[req.write_index] <= wr_sample;
		fast_rd_q     <= fast_mem[fast_addr_q];
		fast_rd_vld_q <= fast_vld_q[fast_addr_q];
	end

	assign fast_word = fast_rd_vld_q ? fast_rd_q : '0;

	// Slow read position, wrapped into the store.
	assign slow_pos = 7'(3'(req.port - PORT_SLOW_FIRST))
		+ (slow_half_q ? 7'(SLOW_DEPTH / 2) : 7'd0);
	assign slow_pos_wrap = (slow_pos >= 7'(SLOW_DEPTH)) ? slow_pos - 7'(SLOW_DEPTH) : slow_pos;
	assign slow_addr     = slow_pos_wrap[SLOW_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_slow && slow_wr_ok)
			slow_mem[req.write_index[SLOW_AW-1:0]] <= wr_sample;
		if (cmd.start_slow) begin
			slow_rd_q     <= slow_mem[slow_addr];
			slow_rd_vld_q <= slow_vld_q[slow_addr];
		end
	end

	assign slow_word = slow_rd_vld_q ? slow_rd_q : '0;

	// Fast address walks the channel's samples in steps of the channel count.
	assign fast_addr_start = FAST_AW'(req.port) + (fast_half_q ? FAST_AW'(FAST_HALF_OFS) : '0);
	assign fast_addr_inc   = {1'b0, fast_addr_q} + (FAST_AW + 1)'(CHANNELS);
	assign fast_addr_nxt   = (fast_addr_inc >= (FAST_AW + 1)'(FAST_DEPTH))
		? FAST_AW'(fast_addr_inc - (FAST_AW + 1)'(FAST_DEPTH)) : fast_addr_inc[FAST_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.start_fast)
			fast_addr_q <= fast_addr_start;
		else if (cmd.fetch)
			fast_addr_q <= fast_addr_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_pend_s1 <= 1'b0;
		else
			rd_pend_s1 <= cmd.fetch;
	end

	// Sample window: the oldest fetched sample ends up in tap zero.
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			for (int i = 0; i < TAPS - 1; i++)
				taps_q[i] <= taps_q[i+1];
			taps_q[TAPS-1] <= fast_word;
		end
	end

	// Partial results, their sum and the scaled quotient.
	always_ff @(posedge clk) begin
		part_s2[0] <= mid3(taps_q[0], taps_q[1], taps_q[2]);
		part_s2[1] <= mid3(taps_q[3], taps_q[4], taps_q[5]);
		part_s2[2] <= pick4(taps_q[6], taps_q[7], taps_q[8], taps_q[9]);
		sum_s3     <= SUM_W'(part_s2[0]) + SUM_W'(part_s2[1]) + SUM_W'(part_s2[2]);
		prod_s4    <= PROD_W'(sum_s3) * PROD_W'(DIV_MUL);
	end

	assign quot = prod_s4 >> DIV_SH;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			unique case (cmd.out_sel)
				SRC_FAST: begin
					rsp_q.value <= VALUE_W'(quot);
					rsp_q.error <= 1'b0;
				end
				SRC_SLOW: begin
					rsp_q.value <= VALUE_W'(slow_word);
					rsp_q.error <= 1'b0;
				end
				default: begin
					rsp_q.value <= '0;
					rsp_q.error <= 1'b1;
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

@@ sv/meab_ctrl.sv @@
module meab_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  meab_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output meab_pkg::dp_cmd_t cmd
);
	import meab_pkg::*;

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	src_t              kind_q;
	src_t              kind_d;
	logic [TAP_CW-1:0] tap_q;
	logic [TAP_CW-1:0] tap_d;
	logic              out_valid_q;
	logic              accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= SRC_FAST;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			tap_q   <= tap_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		tap_d   = tap_q;
		cmd     = '0;
		cmd.out_sel = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.command)
						CMD_WR_FAST:   cmd.wr_fast   = 1'b1;
						CMD_WR_SLOW:   cmd.wr_slow   = 1'b1;
						CMD_FAST_DONE: cmd.flip_fast = 1'b1;
						CMD_SLOW_DONE: cmd.flip_slow = 1'b1;
						CMD_READ: begin
							priority if (req.port <= PORT_FAST_LAST) begin
								cmd.start_fast = 1'b1;
								kind_d  = SRC_FAST;
								tap_d   = '0;
								state_d = ST_FETCH;
							end else if (req.port <= PORT_SLOW_LAST) begin
								cmd.start_slow = 1'b1;
								kind_d  = SRC_SLOW;
								state_d = ST_DONE;
							end else begin
								kind_d  = SRC_ERR;
								state_d = ST_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				if (tap_q == TAP_CW'(TAPS - 1)) begin
					tap_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					tap_d = tap_q + 1'b1;
				end
			end
			ST_DRAIN: state_d = ST_PART;
			ST_PART:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ sv/median_estimate_adc_buffer.sv @@
// Sample writes and half events give no response. A slow-port or invalid-port read goes
// straight to the done state; a fast-port read first fetches ten samples from the fast
// store, then passes drain, partials, sum and divide. Either read then loads the output
// register, waiting while an earlier response is still held; no new request is taken
// before that load. Reset clears both stores to read as zero and sets both half selects
// to the upper half; the block is ready as soon as reset is released.
module median_estimate_adc_buffer
	import meab_pkg::*;
#(
	parameter int SLOW_DEPTH  = meab_pkg::SLOW_DEPTH_DEF,
	parameter int SAMPLE_BITS = meab_pkg::SAMPLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  meab_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output meab_pkg::rsp_t rsp
);

	// The controller sequences each request and owns both handshakes. The
	// datapath holds the stores, the half selects, the ten-sample window and
	// the median/divide pipeline, and acts only on the controller's commands.
	dp_cmd_t cmd;

	// The response register parts the two sides: a new request is taken while
	// an earlier response still waits for the consumer, and only a read that
	// finishes while the slot is full waits in the controller.
	meab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// A fast read walks the selected channel in steps of three through the
	// single read port of the fast store; that port sets the read time.
	meab_dp #(
		.SLOW_DEPTH  (SLOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// Store accesses never coincide: writes and flips happen only when a request
	// is accepted, fetches only while the controller is busy.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_fast, cmd.wr_slow, cmd.flip_fast, cmd.flip_slow,
			cmd.start_fast, cmd.start_slow, cmd.fetch}))
		else $error("datapath commands overlap");

	// An accepted fast-port read starts fetching in the next cycle.
	a_fast_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.command == CMD_READ && req.port <= PORT_FAST_LAST)
		|=> cmd.fetch)
		else $error("fast read did not start fetching");

	// A held response is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !cmd.load_out)
		else $error("response overwritten while stalled");

	// The controller takes no request while it works on a read.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> !req_ready)
		else $error("request accepted during fetch");

endmodule
